>>> hdl/cwfl_pkg.sv
// types and constants shared by the command watchdog failsafe landing block
`default_nettype none

package cwfl_pkg;

	localparam int unsigned WdW      = 13;
	localparam int unsigned ThrustW  = 8;
	localparam int unsigned ElapsedW = 17;
	localparam int unsigned PeriodW  = 8;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 17;

	localparam logic [WdW-1:0]      TimeoutRst  = WdW'(4000);
	localparam logic [ThrustW-1:0]  ThrustRst   = ThrustW'(74);
	localparam logic [ElapsedW-1:0] DurationRst = ElapsedW'(23000);
	localparam logic [PeriodW-1:0]  PeriodRst   = PeriodW'(83);

	typedef enum logic [CfgIdxW-1:0] {
		CFG_MONITOR_ENABLE = 3'd0,
		CFG_CMD_TIMEOUT    = 3'd1,
		CFG_LANDING_THRUST = 3'd2,
		CFG_LANDING_DUR    = 3'd3,
		CFG_CMD_PERIOD     = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic tick;
		logic kick;
		logic emergency_request;
	} in_item_t;

	typedef struct packed {
		logic               send_command;
		logic [ThrustW-1:0] thrust;
		logic               landing_active;
		logic               became_active;
		logic               landing_finished;
	} out_item_t;

endpackage

`default_nettype wire

>>> hdl/command_watchdog_failsafe_landing.sv
// command watchdog with failsafe landing sequence, top level
// an accepted item sits in the input register; its result enters the output register when it advances
// throughput: one item per cycle; an input register and an output register with stall on both
// sides, so a new item is taken while a finished result still waits
// reset: arst_n clears all counters, latch, landing state and valid flags; config goes to defaults
`default_nettype none

module command_watchdog_failsafe_landing (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [cwfl_pkg::CfgIdxW-1:0]        cfg_index,
	input  wire logic [cwfl_pkg::CfgDataW-1:0]       cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire cwfl_pkg::in_item_t                  in_item,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output cwfl_pkg::out_item_t                      out_item
);
	import cwfl_pkg::*;

	// configuration
	logic                monitor_enable_q;
	logic [WdW-1:0]      timeout_q;
	logic [ThrustW-1:0]  thrust_q;
	logic [ElapsedW-1:0] duration_q;
	logic [PeriodW-1:0]  period_q;

	// block state
	logic [WdW-1:0]      wd_count_q;
	logic                req_latch_q;
	logic                landing_on_q;
	logic [ElapsedW-1:0] elapsed_q;
	logic [PeriodW-1:0]  period_count_q;

	// input stage
	logic     valid_s1;
	in_item_t item_s1;

	logic advance;
	logic in_accept;

	logic [WdW-1:0]      wd_next;
	logic                latch_next;
	logic                landing_next;
	logic [ElapsedW-1:0] elapsed_next;
	logic [PeriodW-1:0]  pcount_next;
	logic [PeriodW-1:0]  period_eff;
	out_item_t           result;

	assign advance   = valid_s1 && (!out_valid || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			monitor_enable_q <= 1'b0;
			timeout_q        <= TimeoutRst;
			thrust_q         <= ThrustRst;
			duration_q       <= DurationRst;
			period_q         <= PeriodRst;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MONITOR_ENABLE: monitor_enable_q <= cfg_data[0];
				CFG_CMD_TIMEOUT:    timeout_q        <= cfg_data[WdW-1:0];
				CFG_LANDING_THRUST: thrust_q         <= cfg_data[ThrustW-1:0];
				CFG_LANDING_DUR:    duration_q       <= cfg_data[ElapsedW-1:0];
				CFG_CMD_PERIOD:     period_q         <= cfg_data[PeriodW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		period_eff   = (period_q == '0) ? PeriodW'(1) : period_q;
		latch_next   = req_latch_q || item_s1.emergency_request;
		landing_next = landing_on_q;
		elapsed_next = elapsed_q;
		pcount_next  = period_count_q;
		result       = '0;

		if (item_s1.kick) begin
			wd_next = '0;
		end else if (item_s1.tick && (wd_count_q != '1)) begin
			wd_next = wd_count_q + WdW'(1);
		end else begin
			wd_next = wd_count_q;
		end

		if (item_s1.tick) begin
			if (landing_on_q) begin
				if (elapsed_q != '1) begin
					elapsed_next = elapsed_q + ElapsedW'(1);
				end
				pcount_next = period_count_q + PeriodW'(1);
				// period boundary: keep commanding or end the landing
				if (pcount_next >= period_eff) begin
					pcount_next = '0;
					if (elapsed_next < duration_q) begin
						result.send_command = 1'b1;
					end else begin
						landing_next            = 1'b0;
						result.landing_finished = 1'b1;
					end
				end
			end else if (monitor_enable_q && (latch_next || (wd_next > timeout_q))) begin
				latch_next           = 1'b0;
				landing_next         = 1'b1;
				elapsed_next         = '0;
				pcount_next          = '0;
				result.became_active = 1'b1;
				result.send_command  = 1'b1;
			end
		end

		result.thrust         = result.send_command ? thrust_q : '0;
		result.landing_active = landing_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			out_valid      <= 1'b0;
			wd_count_q     <= '0;
			req_latch_q    <= 1'b0;
			landing_on_q   <= 1'b0;
			elapsed_q      <= '0;
			period_count_q <= '0;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid      <= 1'b1;
				wd_count_q     <= wd_next;
				req_latch_q    <= latch_next;
				landing_on_q   <= landing_next;
				elapsed_q      <= elapsed_next;
				period_count_q <= pcount_next;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1 <= in_item;
		end
		if (advance) begin
			out_item <= result;
		end
	end

	// a landing cannot start and end on the same item
	a_start_end_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_item.became_active && out_item.landing_finished))
		else $error("start and finish pulses together");

	// no thrust without a command
	a_thrust_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_item.send_command) |-> (out_item.thrust == '0))
		else $error("thrust without command");

	// a start always commands and leaves the landing active
	a_start_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.became_active) |->
			(out_item.send_command && out_item.landing_active))
		else $error("start without command or active flag");

	// state register tracks what the last result reported
	a_state_match: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (landing_on_q == out_item.landing_active))
		else $error("landing state differs from reported flag");

endmodule

`default_nettype wire
